FILE: rtl/core/bls_pkg.sv
// types, constants and octant mapping functions for the bresenham line stepper
`default_nettype none

package bls_pkg;

   localparam int COORD_BITS = 12;
   localparam int POS_BITS   = COORD_BITS + 1;
   localparam int DELTA_BITS = COORD_BITS + 2;
   localparam int ERR_BITS   = COORD_BITS + 3;

   localparam logic ACTION_START   = 1'b0;
   localparam logic ACTION_ADVANCE = 1'b1;

   localparam logic [2:0] OCT_0 = 3'd0;
   localparam logic [2:0] OCT_1 = 3'd1;
   localparam logic [2:0] OCT_2 = 3'd2;
   localparam logic [2:0] OCT_3 = 3'd3;
   localparam logic [2:0] OCT_4 = 3'd4;
   localparam logic [2:0] OCT_5 = 3'd5;
   localparam logic [2:0] OCT_6 = 3'd6;
   localparam logic [2:0] OCT_7 = 3'd7;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [POS_BITS-1:0]   pos_type;
   typedef logic signed [DELTA_BITS-1:0] delta_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;

   typedef struct packed {
      logic      action;
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
   } req_word_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      logic      point_valid;
      logic      last_point;
   } rsp_word_type;

   typedef struct packed {
      pos_type a;
      pos_type b;
   } pos_pair_type;

   // real coordinates into octant zero
   function automatic pos_pair_type to_zero(input logic [2:0] oct, input pos_type x,
                                            input pos_type y);
      pos_pair_type r;
      unique case (oct)
         OCT_0: begin r.a = x;  r.b = y;  end
         OCT_1: begin r.a = y;  r.b = x;  end
         OCT_2: begin r.a = y;  r.b = -x; end
         OCT_3: begin r.a = -x; r.b = y;  end
         OCT_4: begin r.a = -x; r.b = -y; end
         OCT_5: begin r.a = -y; r.b = -x; end
         OCT_6: begin r.a = -y; r.b = x;  end
         OCT_7: begin r.a = x;  r.b = -y; end
         default: begin r.a = x; r.b = y; end
      endcase
      return r;
   endfunction

   // octant zero back into real coordinates
   function automatic pos_pair_type from_zero(input logic [2:0] oct, input pos_type zx,
                                              input pos_type zy);
      pos_pair_type r;
      unique case (oct)
         OCT_0: begin r.a = zx;  r.b = zy;  end
         OCT_1: begin r.a = zy;  r.b = zx;  end
         OCT_2: begin r.a = -zy; r.b = zx;  end
         OCT_3: begin r.a = -zx; r.b = zy;  end
         OCT_4: begin r.a = -zx; r.b = -zy; end
         OCT_5: begin r.a = -zy; r.b = -zx; end
         OCT_6: begin r.a = zy;  r.b = -zx; end
         OCT_7: begin r.a = zx;  r.b = -zy; end
         default: begin r.a = zx; r.b = zy; end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bls_core.sv
// line state registers and the per-word start and step logic
`default_nettype none

module bls_core
   import bls_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step_en,
   input  wire req_word_type word,
   output rsp_word_type      result
);

   logic         line_active_ff, line_active_in;
   logic [2:0]   octant_ff, octant_in;
   pos_type      major_pos_ff, major_pos_in;
   pos_type      minor_pos_ff, minor_pos_in;
   pos_type      major_end_ff, major_end_in;
   err_type      error_ff, error_in;
   delta_type    twice_minor_ff, twice_minor_in;
   delta_type    twice_major_ff, twice_major_in;

   pos_type                xs, ys, xe, ye, dx, dy;
   logic [POS_BITS-1:0]    adx, ady;
   logic [2:0]             new_oct;
   pos_pair_type           z0, z1, real_pt;
   pos_type                dmaj, dmin;
   delta_type              tmaj, tmin;
   pos_type                step_major, step_minor;
   err_type                step_err;
   logic                   start_last, step_last;

   // start path
   always_comb begin
      xs = pos_type'($signed(word.x_start));
      ys = pos_type'($signed(word.y_start));
      xe = pos_type'($signed(word.x_end));
      ye = pos_type'($signed(word.y_end));
      dx = xe - xs;
      dy = ye - ys;
      adx = dx[POS_BITS-1] ? POS_BITS'(-dx) : POS_BITS'(dx);
      ady = dy[POS_BITS-1] ? POS_BITS'(-dy) : POS_BITS'(dy);
      priority if (!dx[POS_BITS-1] && !dy[POS_BITS-1]) begin
         new_oct = (adx >= ady) ? OCT_0 : OCT_1;
      end else if (dx[POS_BITS-1] && !dy[POS_BITS-1]) begin
         new_oct = (ady >= adx) ? OCT_2 : OCT_3;
      end else if (dx[POS_BITS-1]) begin
         new_oct = (adx >= ady) ? OCT_4 : OCT_5;
      end else begin
         new_oct = (ady >= adx) ? OCT_6 : OCT_7;
      end
      z0 = to_zero(new_oct, xs, ys);
      z1 = to_zero(new_oct, xe, ye);
      dmaj = z1.a - z0.a;
      dmin = z1.b - z0.b;
      tmaj = {dmaj, 1'b0};
      tmin = {dmin, 1'b0};
      start_last = (z0.a == z1.a);
   end

   // step path
   always_comb begin
      step_major = major_pos_ff + pos_type'(1);
      if (error_ff > 0) begin
         step_minor = minor_pos_ff + pos_type'(1);
         step_err   = error_ff + err_type'(twice_minor_ff) - err_type'(twice_major_ff);
      end else begin
         step_minor = minor_pos_ff;
         step_err   = error_ff + err_type'(twice_minor_ff);
      end
      real_pt   = from_zero(octant_ff, step_major, step_minor);
      step_last = (step_major == major_end_ff);
   end

   always_comb begin
      line_active_in = line_active_ff;
      octant_in      = octant_ff;
      major_pos_in   = major_pos_ff;
      minor_pos_in   = minor_pos_ff;
      major_end_in   = major_end_ff;
      error_in       = error_ff;
      twice_minor_in = twice_minor_ff;
      twice_major_in = twice_major_ff;
      result         = '0;
      unique case (word.action)
         ACTION_START: begin
            octant_in      = new_oct;
            major_pos_in   = z0.a;
            minor_pos_in   = z0.b;
            major_end_in   = z1.a;
            twice_major_in = tmaj;
            twice_minor_in = tmin;
            error_in       = err_type'(tmin) - err_type'(dmaj);
            line_active_in = !start_last;
            result.point_x     = word.x_start;
            result.point_y     = word.y_start;
            result.point_valid = 1'b1;
            result.last_point  = start_last;
         end
         ACTION_ADVANCE: begin
            if (line_active_ff) begin
               major_pos_in   = step_major;
               minor_pos_in   = step_minor;
               error_in       = step_err;
               line_active_in = !step_last;
               result.point_x     = real_pt.a[COORD_BITS-1:0];
               result.point_y     = real_pt.b[COORD_BITS-1:0];
               result.point_valid = 1'b1;
               result.last_point  = step_last;
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
         octant_ff      <= OCT_0;
         major_pos_ff   <= '0;
         minor_pos_ff   <= '0;
         major_end_ff   <= '0;
         error_ff       <= '0;
         twice_minor_ff <= '0;
         twice_major_ff <= '0;
      end else if (step_en) begin
         line_active_ff <= line_active_in;
         octant_ff      <= octant_in;
         major_pos_ff   <= major_pos_in;
         minor_pos_ff   <= minor_pos_in;
         major_end_ff   <= major_end_in;
         error_ff       <= error_in;
         twice_minor_ff <= twice_minor_in;
         twice_major_ff <= twice_major_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/bresenham_line_stepper_unit.sv
// Bresenham line stepper top level: input register, line core, result register
//
// The req channel carries one word per command: a start word (action 0) loads
// two endpoints and returns the start pixel, an advance word (action 1) steps
// the line one pixel along its major axis. Every req word gives exactly one
// rsp word; an advance with no line in progress returns point_valid 0 and a
// zero point. The final pixel of a line carries last_point.
// A word is taken when req_valid is high and req_stall low, and its result
// reaches rsp after passing from the input register into the result register.
// One word is accepted every cycle while rsp_stall is low; the limit is the add
// and compare of the error update, combinational between the two registers.
// When the receiver holds rsp_stall, the result register keeps its word and
// the input register fills; req_stall then rises until rsp moves again.
// Synchronous reset empties both registers and drops any line in progress.
`default_nettype none

module bresenham_line_stepper_unit
   import bls_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;
   rsp_word_type core_result;
   logic         out_load;
   logic         req_take;
   logic         rsp_take;

   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !out_load;
   assign req_take  = req_valid && !req_stall;

   bls_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (out_load),
      .word    (in_word_ff),
      .result  (core_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (out_load) begin
         out_word_ff <= core_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("req_stall raised with an empty input register");

   a_held_word_not_overwritten: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !out_load)
      else $error("stalled result word overwritten");

   a_load_gives_valid: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid)
      else $error("loaded result word not presented");

   a_start_always_valid: assert property (@(posedge clock) disable iff (reset)
      (out_load && in_word_ff.action == ACTION_START) |-> core_result.point_valid)
      else $error("start word produced no pixel");

endmodule

`default_nettype wire
